>>> sv/amt_pkg.sv
// shared constants, types and helpers for the adaptive mean threshold block
package amt_pkg;

  // window and line geometry
  localparam int BLOCK_SIZE = 15;
  localparam int MAX_WIDTH  = 2048;
  localparam int HALF_B     = BLOCK_SIZE / 2;
  localparam int EXT_B      = BLOCK_SIZE - 1 - HALF_B;
  localparam int STORE_ROWS = BLOCK_SIZE - 1;
  localparam int NCELL      = BLOCK_SIZE;

  // field and register widths
  localparam int PIX_W  = 8;
  localparam int TOFF_W = 9;
  localparam int DIM_W  = 12;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 2;

  // derived widths
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int SLOT_W   = $clog2(STORE_ROWS);
  localparam int ROW_W    = DIM_W;
  localparam int CMP_W    = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
  localparam int LS_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int CS_W     = $clog2(BLOCK_SIZE * 255 + 1);
  localparam int SUM_W    = $clog2(BLOCK_SIZE * BLOCK_SIZE * 255 + 1);
  localparam int PEND_W   = $clog2(EXT_B * MAX_WIDTH + EXT_B + 1);
  localparam int THR_W    = PIX_W + 3;

  // reciprocal of the window area for the truncated mean
  localparam int AREA       = BLOCK_SIZE * BLOCK_SIZE;
  localparam int MEAN_SHIFT = SUM_W + $clog2(AREA);
  localparam int RECIP_W    = SUM_W + 2;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << MEAN_SHIFT) + AREA - 1) / AREA);

  // register indexes
  localparam logic [IDX_W-1:0] REG_OFFSET = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

  // register reset values
  localparam logic [TOFF_W-1:0] TOFF_RESET   = 9'd5;
  localparam logic [DIM_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = 12'd480;

  // pixel values
  localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;
  localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;

  // raster position with line store ring slot
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] slot;
    logic [COL_W-1:0]  col;
  } amt_pos_t;

  // one cell of the column sum chain
  typedef struct packed {
    logic            live;
    logic [CS_W-1:0] sum;
  } amt_cell_t;

  // store read request
  typedef struct packed {
    logic             en;
    logic [LS_AW-1:0] a_addr;
    logic [LS_AW-1:0] b_addr;
    logic [COL_W-1:0] cs_addr;
  } amt_rd_t;

  // store write request
  typedef struct packed {
    logic             en;
    logic [LS_AW-1:0] addr;
    logic [PIX_W-1:0] pix;
    logic             cs_en;
    logic [COL_W-1:0] cs_addr;
    logic [CS_W-1:0]  cs;
  } amt_wr_t;

  // line store address of a ring slot and column
  function automatic logic [LS_AW-1:0] ls_addr(logic [SLOT_W-1:0] slot, logic [COL_W-1:0] col);
    return LS_AW'(slot) * LS_AW'(MAX_WIDTH) + LS_AW'(col);
  endfunction

  // step a raster position by one pixel
  function automatic amt_pos_t pos_advance(amt_pos_t p, logic [DIM_W-1:0] w,
                                           logic [DIM_W-1:0] h);
    amt_pos_t         n;
    logic [CMP_W-1:0] c1;
    logic [DIM_W:0]   r1;
    n  = p;
    c1 = CMP_W'(p.col) + CMP_W'(1);
    r1 = {1'b0, p.row} + (DIM_W + 1)'(1);
    if (c1 >= CMP_W'(w)) begin
      n.col  = '0;
      n.slot = (p.slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : p.slot + SLOT_W'(1);
      n.row  = (r1 >= {1'b0, h}) ? '0 : r1[ROW_W-1:0];
    end else begin
      n.col = p.col + COL_W'(1);
    end
    return n;
  endfunction

endpackage

>>> sv/amt_cell.sv
// one cell of the column sum chain: holds a column sum and whether it lies in the current row
module amt_cell import amt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      shift_i,
  input  logic      kill_i,
  input  amt_cell_t d_i,
  output amt_cell_t q_o
);

  logic            live_q, live_d;
  logic [CS_W-1:0] sum_q;

  // a new row start drops everything older than the first column
  assign live_d = d_i.live & ~kill_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (shift_i) begin
      live_q <= live_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sum_q <= d_i.sum;
    end
  end

  assign q_o.live = live_q;
  assign q_o.sum  = sum_q;

endmodule

>>> sv/amt_window.sv
// sliding window sum over a chain of column sum cells, and the truncated window mean
module amt_window import amt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             row_start_i,
  input  logic [CS_W-1:0]  cs_i,
  input  logic             mean_en_i,
  output logic [PIX_W-1:0] mean_o
);

  amt_cell_t                   chain [NCELL];
  logic [SUM_W-1:0]            ws_q, ws_d;
  logic [SUM_W-1:0]            drop;
  logic [SUM_W+RECIP_W-1:0]    prod;
  logic [PIX_W-1:0]            mean_q;

  // chain of cells, newest column sum enters at cell zero
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    amt_cell_t cell_d;
    logic      cell_kill;
    if (k == 0) begin : g_head
      assign cell_d.live = 1'b1;
      assign cell_d.sum  = cs_i;
      assign cell_kill   = 1'b0;
    end else begin : g_body
      assign cell_d    = chain[k-1];
      assign cell_kill = row_start_i;
    end
    amt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_i),
      .kill_i  (cell_kill),
      .d_i     (cell_d),
      .q_o     (chain[k])
    );
  end

  // the last cell holds the column leaving the window
  assign drop = chain[NCELL-1].live ? SUM_W'(chain[NCELL-1].sum) : '0;
  assign ws_d = row_start_i ? SUM_W'(cs_i) : ws_q + SUM_W'(cs_i) - drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= '0;
    end else if (shift_i) begin
      ws_q <= ws_d;
    end
  end

  // mean by reciprocal multiply, registered
  assign prod = (SUM_W + RECIP_W)'(ws_q) * (SUM_W + RECIP_W)'(RECIP);

  always_ff @(posedge clk_i) begin
    if (mean_en_i) begin
      mean_q <= prod[MEAN_SHIFT +: PIX_W];
    end
  end

  assign mean_o = mean_q;

endmodule

>>> sv/amt_store.sv
// line store ring and per-column sums, with registered reads
module amt_store import amt_pkg::*; (
  input  logic             clk_i,
  input  amt_rd_t          rd_i,
  input  amt_wr_t          wr_i,
  output logic [PIX_W-1:0] pix_a_o,
  output logic [PIX_W-1:0] pix_b_o,
  output logic [CS_W-1:0]  cs_o
);

  logic [PIX_W-1:0] line_mem [LS_DEPTH];
  logic [CS_W-1:0]  cs_mem [MAX_WIDTH];
  logic [PIX_W-1:0] pix_a_q, pix_b_q;
  logic [CS_W-1:0]  cs_q;

  // line store: one write, two reads
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      line_mem[wr_i.addr] <= wr_i.pix;
    end
    if (rd_i.en) begin
      pix_a_q <= line_mem[rd_i.a_addr];
      pix_b_q <= line_mem[rd_i.b_addr];
    end
  end

  // column sums: one write, one read
  always_ff @(posedge clk_i) begin
    if (wr_i.cs_en) begin
      cs_mem[wr_i.cs_addr] <= wr_i.cs;
    end
    if (rd_i.en) begin
      cs_q <= cs_mem[rd_i.cs_addr];
    end
  end

  assign pix_a_o = pix_a_q;
  assign pix_b_o = pix_b_q;
  assign cs_o    = cs_q;

endmodule

>>> sv/adaptive_mean_threshold_top.sv
// top level of the streaming adaptive mean threshold over a square box window
// Gray pixels enter in raster order, one beat per clock while tready is high, and
// binarised pixels leave in raster order, half a window of rows and columns behind: a
// pixel beat gives a result once that many pixels are pending, and a flush beat drains
// one pending result, the last result of a frame carrying tlast. A beat passes three
// register stages (store read, store write and window update, mean multiply) and the
// compare into the output register; the output register is backed by a one-beat skid
// stage, so the sustained rate is one beat per clock, set by the column sum update and
// sliding window add, while the skid stage stays empty. After reset the line store and
// column sums are cleared one entry per cycle, all 28672 line store entries, during
// which no beat is taken; register writes are taken at any time but belong to idle
// periods only.
module adaptive_mean_threshold_top import amt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // input stream
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // in_pixel [7:0]
  input  logic [0:0]       s_axis_tuser_i,   // kind [0]
  // result stream
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // out_pixel [7:0]
  output logic             m_axis_tlast_o,
  // register writes
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  // registers
  logic [TOFF_W-1:0] toff_q;
  logic [DIM_W-1:0]  width_q, height_q;

  // control state
  logic              clearing_q;
  logic [LS_AW-1:0]  clr_q;
  amt_pos_t          in_pos_q, out_pos_q;
  logic [PEND_W-1:0] pending_q;

  // pipeline
  logic              en, acc, is_pix, emit;
  logic [DIM_W-1:0]  eff_w, eff_h;
  logic [PEND_W-1:0] delay;
  logic              interior, frame_last;
  logic [CMP_W-1:0]  co_e;
  logic [DIM_W:0]    ro_e;

  logic              s1_valid_q, s1_pix_q, s1_emit_q, s1_thr_q, s1_last_q, s1_row_start_q;
  logic [PIX_W-1:0]  s1_pixel_q;
  logic [LS_AW-1:0]  s1_in_addr_q, s1_out_addr_q;
  logic [COL_W-1:0]  s1_col_q;

  logic              s2_valid_q, s2_thr_q, s2_last_q, s2_fwd_q;
  logic [PIX_W-1:0]  s2_pixel_q;

  logic              s3_valid_q, s3_thr_q, s3_last_q;
  logic [PIX_W-1:0]  s3_centre_q;

  logic              out_valid_q, out_last_q, skid_valid_q, skid_last_q;
  logic [PIX_W-1:0]  out_pix_q, skid_pix_q;

  // store and window signals
  amt_rd_t           rd;
  amt_wr_t           wr;
  logic [PIX_W-1:0]  old_pix, centre_rd, mean;
  logic [CS_W-1:0]   cs_rd, cs_sum, cs_new;
  logic              s1_write;

  // result compare
  logic [THR_W-1:0]  limit;
  logic              below;
  logic [PIX_W-1:0]  result;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toff_q   <= TOFF_RESET;
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OFFSET: toff_q   <= cfg_wdata_i[TOFF_W-1:0];
        REG_WIDTH:  width_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_wdata_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      if (clr_q == LS_AW'(LS_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end else begin
        clr_q <= clr_q + LS_AW'(1);
      end
    end
  end

  // effective frame size and result delay
  always_comb begin
    if (width_q < DIM_W'(BLOCK_SIZE)) begin
      eff_w = DIM_W'(BLOCK_SIZE);
    end else if (CMP_W'(width_q) > CMP_W'(MAX_WIDTH)) begin
      eff_w = DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = width_q;
    end
    eff_h = (height_q < DIM_W'(BLOCK_SIZE)) ? DIM_W'(BLOCK_SIZE) : height_q;
  end

  assign delay = PEND_W'(EXT_B) * PEND_W'(eff_w) + PEND_W'(EXT_B);

  // position of the result pixel in the frame
  assign co_e       = CMP_W'(out_pos_q.col);
  assign ro_e       = (DIM_W + 1)'(out_pos_q.row);
  assign interior   = (ro_e >= (DIM_W + 1)'(HALF_B)) &&
                      (ro_e + (DIM_W + 1)'(EXT_B) < (DIM_W + 1)'(eff_h)) &&
                      (co_e >= CMP_W'(HALF_B)) &&
                      (co_e + CMP_W'(EXT_B) < CMP_W'(eff_w));
  assign frame_last = (ro_e == (DIM_W + 1)'(eff_h) - (DIM_W + 1)'(1)) &&
                      (co_e == CMP_W'(eff_w) - CMP_W'(1));

  // handshake and beat decode
  assign en              = ~skid_valid_q;
  assign s_axis_tready_o = en & ~clearing_q;
  assign acc             = s_axis_tvalid_i & s_axis_tready_o;
  assign is_pix          = ~s_axis_tuser_i[0];
  assign emit            = is_pix ? (pending_q >= delay) : (pending_q != '0);

  // raster positions and pending count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q  <= '0;
      out_pos_q <= '0;
      pending_q <= '0;
    end else if (acc) begin
      if (is_pix) begin
        in_pos_q <= pos_advance(in_pos_q, eff_w, eff_h);
        if (!emit) begin
          pending_q <= pending_q + PEND_W'(1);
        end
      end else if (emit) begin
        pending_q <= pending_q - PEND_W'(1);
      end
      if (emit) begin
        out_pos_q <= pos_advance(out_pos_q, eff_w, eff_h);
      end
    end
  end

  // store access
  assign rd.en      = en;
  assign rd.a_addr  = ls_addr(in_pos_q.slot, in_pos_q.col);
  assign rd.b_addr  = s1_out_addr_q;
  assign rd.cs_addr = in_pos_q.col;

  assign s1_write = en & s1_valid_q & s1_pix_q;
  assign cs_sum   = cs_rd + CS_W'(s1_pixel_q);
  assign cs_new   = cs_rd - CS_W'(old_pix) + CS_W'(s1_pixel_q);

  always_comb begin
    if (clearing_q) begin
      wr.en      = 1'b1;
      wr.addr    = clr_q;
      wr.pix     = '0;
      wr.cs_en   = (clr_q < LS_AW'(MAX_WIDTH));
      wr.cs_addr = clr_q[COL_W-1:0];
      wr.cs      = '0;
    end else begin
      wr.en      = s1_write;
      wr.addr    = s1_in_addr_q;
      wr.pix     = s1_pixel_q;
      wr.cs_en   = s1_write;
      wr.cs_addr = s1_col_q;
      wr.cs      = cs_new;
    end
  end

  amt_store u_store (
    .clk_i   (clk_i),
    .rd_i    (rd),
    .wr_i    (wr),
    .pix_a_o (old_pix),
    .pix_b_o (centre_rd),
    .cs_o    (cs_rd)
  );

  amt_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_i     (s1_write),
    .row_start_i (s1_row_start_q),
    .cs_i        (cs_sum),
    .mean_en_i   (en),
    .mean_o      (mean)
  );

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc & (is_pix | emit);
      s2_valid_q <= s1_valid_q & s1_emit_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pix_q       <= is_pix;
      s1_emit_q      <= emit;
      s1_thr_q       <= is_pix & interior;
      s1_last_q      <= frame_last;
      s1_row_start_q <= (in_pos_q.col == '0);
      s1_pixel_q     <= s_axis_tdata_i;
      s1_in_addr_q   <= ls_addr(in_pos_q.slot, in_pos_q.col);
      s1_out_addr_q  <= ls_addr(out_pos_q.slot, out_pos_q.col);
      s1_col_q       <= in_pos_q.col;

      s2_thr_q   <= s1_thr_q;
      s2_last_q  <= s1_last_q;
      s2_pixel_q <= s1_pixel_q;
      s2_fwd_q   <= s1_pix_q & (s1_out_addr_q == s1_in_addr_q);

      s3_thr_q    <= s2_thr_q;
      s3_last_q   <= s2_last_q;
      s3_centre_q <= s2_fwd_q ? s2_pixel_q : centre_rd;
    end
  end

  // threshold against mean minus offset
  assign limit  = THR_W'(mean) - {{(THR_W - TOFF_W){toff_q[TOFF_W-1]}}, toff_q};
  assign below  = $signed(THR_W'(s3_centre_q)) < $signed(limit);
  assign result = s3_thr_q ? (below ? PIX_LOW : PIX_HIGH) : s3_centre_q;

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= s3_valid_q;
      end
    end else if (s3_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_pix_q  <= skid_pix_q;
        out_last_q <= skid_last_q;
      end else begin
        out_pix_q  <= result;
        out_last_q <= s3_last_q;
      end
    end else if (en) begin
      skid_pix_q  <= result;
      skid_last_q <= s3_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
